// ===== sv/dual_rssi_window_median_top_macros.svh =====
// Assertion macros for the dual signal-strength window median block.
// Included by the top level; define ASSERT_OFF to compile them out.
`ifndef DUAL_RSSI_WINDOW_MEDIAN_TOP_MACROS_SVH
`define DUAL_RSSI_WINDOW_MEDIAN_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define RDWM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdwm assertion failed");

// Next-cycle implication, disabled during reset.
`define RDWM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdwm assertion failed");

`else

`define RDWM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RDWM_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/rdwm_pkg.sv =====
// Package for the dual signal-strength window median block.
// Holds the item op codes, the sequencer states and the lane control struct.
`timescale 1ns / 1ps
`default_nettype none

package rdwm_pkg;

  // Op codes carried by an input item.
  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_LATCH = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  // Median reported when no sample is stored.
  localparam logic signed [7:0] EMPTY_MEDIAN = -8'sd128;

  // Control from the sequencer to each lane.
  typedef struct packed {
    logic write;
    logic search;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== sv/rdwm_if.sv =====
// Valid/ready channel interfaces for the window median block.
// rdwm_in_if carries sample, latch and clear items; rdwm_out_if carries medians.
`timescale 1ns / 1ps
`default_nettype none

interface rdwm_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic signed [7:0] central_sample;
  logic signed [7:0] peripheral_sample;
  logic              transfer_ok;

  modport source (output valid, op, central_sample, peripheral_sample, transfer_ok,
                  input ready);
  modport sink (input valid, op, central_sample, peripheral_sample, transfer_ok,
                output ready);
endinterface

interface rdwm_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] central_median;
  logic signed [7:0] peripheral_median;
  logic [2:0]        sample_count;

  modport source (output valid, central_median, peripheral_median, sample_count,
                  input ready);
  modport sink (input valid, central_median, peripheral_median, sample_count,
                output ready);
endinterface

`default_nettype wire

// ===== sv/dual_rssi_window_median_top.sv =====
// Top level of the dual signal-strength window median block.
// Depends on rdwm_pkg, rdwm_if, rdwm_lane and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_rssi_window_median_top_macros.svh"

// Keeps the last WINDOW_DEPTH central and peripheral samples in two rings and
// reports the median of each on a latch item with a good transfer (-128 for
// both when empty). Store, clear and unused-op items are handled in the idle
// state, and so is a latch item whose transfer failed. A latch item with a good
// transfer on a non-empty history passes through a search state, where the two
// lanes scan the stored ring entries, one per cycle, as median candidate,
// counting its rank against all stored entries in parallel, then an emit state. The
// result sits in an output register, so the next item is taken while it waits
// to be collected; a later latch holds in its emit state for as long as an
// earlier result still waits there.
module dual_rssi_window_median_top #(
  parameter int WINDOW_DEPTH = 7
) (
  input  wire         clk,
  input  wire         rst,
  rdwm_in_if.sink     in_ch,
  rdwm_out_if.source  out_ch
);
  import rdwm_pkg::*;

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  state_t            state;
  state_t            state_next;
  lane_ctl_t         ctl;
  logic [IDX_W-1:0]  cand;
  logic [IDX_W-1:0]  write_slot;
  logic [CNT_W-1:0]  fill;
  logic              acc;
  logic              out_free;
  logic              out_valid;
  logic signed [7:0] out_central;
  logic signed [7:0] out_peripheral;
  logic [2:0]        out_count;
  logic signed [7:0] central_med;
  logic signed [7:0] peripheral_med;

  assign in_ch.ready = (state == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  // Sequencer: next state and lane controls.
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (in_ch.op)
            OP_STORE: ctl.write = 1'b1;
            OP_LATCH: begin
              if (in_ch.transfer_ok) begin
                state_next = (fill == '0) ? ST_EMIT : ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        ctl.search = 1'b1;
        if (CNT_W'(cand) == fill - CNT_W'(1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Candidate index steps through the stored entries during the search.
  always_ff @(posedge clk) begin
    if (state == ST_SEARCH) begin
      cand <= cand + IDX_W'(1);
    end else begin
      cand <= '0;
    end
  end

  // Fill count and write slot of the shared history.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      write_slot <= '0;
    end else if (acc && (in_ch.op == OP_STORE)) begin
      if (fill != CNT_W'(WINDOW_DEPTH)) begin
        fill <= fill + CNT_W'(1);
      end
      if (write_slot == IDX_W'(WINDOW_DEPTH - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + IDX_W'(1);
      end
    end else if (acc && (in_ch.op == OP_CLEAR)) begin
      fill       <= '0;
      write_slot <= '0;
    end
  end

  // Channel lanes.
  rdwm_lane #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_central (
    .clk     (clk),
    .ctl     (ctl),
    .wr_slot (write_slot),
    .wr_data (in_ch.central_sample),
    .cand    (cand),
    .fill    (fill),
    .median  (central_med)
  );

  rdwm_lane #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_peripheral (
    .clk     (clk),
    .ctl     (ctl),
    .wr_slot (write_slot),
    .wr_data (in_ch.peripheral_sample),
    .cand    (cand),
    .fill    (fill),
    .median  (peripheral_med)
  );

  // Merge stage: combine the lane medians into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      out_central    <= (fill == '0) ? EMPTY_MEDIAN : central_med;
      out_peripheral <= (fill == '0) ? EMPTY_MEDIAN : peripheral_med;
      out_count      <= 3'(fill);
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.central_median    = out_central;
  assign out_ch.peripheral_median = out_peripheral;
  assign out_ch.sample_count      = out_count;

  // Checks on the sequencer and history bookkeeping.
  `RDWM_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= CNT_W'(WINDOW_DEPTH))
  `RDWM_ASSERT_IMP(a_slot_bound, clk, rst, 1'b1, CNT_W'(write_slot) < CNT_W'(WINDOW_DEPTH))
  `RDWM_ASSERT_NXT(a_latch_search, clk, rst, acc && (in_ch.op == OP_LATCH) && in_ch.transfer_ok && (fill != '0), state == ST_SEARCH)
  `RDWM_ASSERT_NXT(a_emit_loads, clk, rst, (state == ST_EMIT) && out_free, out_valid && (state == ST_IDLE))
  `RDWM_ASSERT_NXT(a_store_fill, clk, rst, acc && (in_ch.op == OP_STORE) && (fill != CNT_W'(WINDOW_DEPTH)), fill == $past(fill) + CNT_W'(1))

endmodule

`default_nettype wire

// ===== sv/rdwm_lane.sv =====
// One channel lane: the sample ring and a rank-counting median search.
// Depends on rdwm_pkg for the lane control struct.
`timescale 1ns / 1ps
`default_nettype none

module rdwm_lane #(
  parameter int WINDOW_DEPTH = 7,
  parameter int IDX_W        = 3,
  parameter int CNT_W        = 3
) (
  input  wire                     clk,
  input  rdwm_pkg::lane_ctl_t     ctl,
  input  wire [IDX_W-1:0]         wr_slot,
  input  wire signed [7:0]        wr_data,
  input  wire [IDX_W-1:0]         cand,
  input  wire [CNT_W-1:0]         fill,
  output logic signed [7:0]       median
);
  import rdwm_pkg::*;

  logic signed [7:0]       ring [WINDOW_DEPTH];
  logic signed [7:0]       cand_val;
  logic [WINDOW_DEPTH-1:0] below;
  logic [CNT_W-1:0]        rank;

  // Ring write; entries are only read after they have been written.
  always_ff @(posedge clk) begin
    if (ctl.write) begin
      ring[wr_slot] <= wr_data;
    end
  end

  // Count the stored entries that sort ahead of the candidate. Equal values
  // are ordered by slot, so exactly one candidate has rank fill/2.
  always_comb begin
    cand_val = ring[cand];
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      below[j] = (CNT_W'(j) < fill) &&
                 ((ring[j] < cand_val) || ((ring[j] == cand_val) && (IDX_W'(j) < cand)));
    end
    rank = CNT_W'($countones(below));
  end

  // Capture the candidate whose rank is the middle one.
  always_ff @(posedge clk) begin
    if (ctl.search && (rank == (fill >> 1))) begin
      median <= cand_val;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for dual_rssi_window_median_top.
// Depends on rdwm_pkg, rdwm_if and the block's RTL; it predicts every median
// result from its own copy of the sample histories and compares field by field.
`timescale 1ns / 1ps

module tb;
  import rdwm_pkg::*;

  localparam int DEPTH = 7;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

  // One expected latch result.
  typedef struct {
    logic signed [7:0] central;
    logic signed [7:0] peripheral;
    logic [2:0]        count;
  } medians_t;

  logic clk;
  logic rst;

  rdwm_in_if  in_ch ();
  rdwm_out_if out_ch ();

  dual_rssi_window_median_top #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predicted sample histories, fill count and write slot.
  logic signed [7:0] central_hist [DEPTH];
  logic signed [7:0] peripheral_hist [DEPTH];
  int                hist_fill;
  int                hist_slot;

  medians_t pending_medians [$];
  int       mismatches;
  bit       quiet;
  int       cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Element at sorted index n/2 of the first n entries, or the empty marker.
  function automatic logic signed [7:0] window_median(input logic signed [7:0] ring [DEPTH],
                                                      input int n);
    logic signed [7:0] work [DEPTH];
    logic signed [7:0] key;
    int                j;
    if (n == 0) return EMPTY_MEDIAN;
    for (int i = 0; i < n; i++) work[i] = ring[i];
    for (int i = 1; i < n; i++) begin
      key = work[i];
      j = i;
      while (j > 0 && work[j - 1] > key) begin
        work[j] = work[j - 1];
        j--;
      end
      work[j] = key;
    end
    return work[n / 2];
  endfunction

  // Applies one accepted item to the predicted state and queues any result.
  task automatic predict_item(input logic [1:0] op, input logic signed [7:0] c,
                              input logic signed [7:0] p, input logic ok);
    medians_t m;
    case (op)
      OP_STORE: begin
        central_hist[hist_slot] = c;
        peripheral_hist[hist_slot] = p;
        if (hist_fill < DEPTH) hist_fill++;
        hist_slot = (hist_slot + 1 == DEPTH) ? 0 : hist_slot + 1;
      end
      OP_LATCH: begin
        if (ok) begin
          m.central = window_median(central_hist, hist_fill);
          m.peripheral = window_median(peripheral_hist, hist_fill);
          m.count = hist_fill[2:0];
          pending_medians.push_back(m);
        end
      end
      OP_CLEAR: begin
        hist_fill = 0;
        hist_slot = 0;
      end
      default: begin
      end
    endcase
  endtask

  // Sends one item after a random gap and predicts it once it is accepted.
  task automatic send_item(input logic [1:0] op, input logic signed [7:0] c,
                           input logic signed [7:0] p, input logic ok);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.central_sample <= c;
    in_ch.peripheral_sample <= p;
    in_ch.transfer_ok <= ok;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(op, c, p, ok);
  endtask

  // Sample values: full range, the extremes, and tight clusters that force ties.
  function automatic logic signed [7:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      1: return 8'(-60 + $signed($urandom_range(0, 6)) - 3);
      default: return 8'($urandom);
    endcase
  endfunction

  // A latch with a good transfer on an empty history, and the ignored items.
  task automatic test_empty_and_ignored();
    send_item(OP_LATCH, 8'sd0, 8'sd0, 1'b1);
    send_item(OP_LATCH, 8'sd55, -8'sd9, 1'b0);
    send_item(OP_UNUSED, -8'sd1, 8'sd127, 1'b1);
    send_item(OP_LATCH, 8'sd0, 8'sd0, 1'b1);
  endtask

  // Field extremes on a partly filled history.
  task automatic test_extremes();
    send_item(OP_STORE, 8'sd127, -8'sd128, 1'b0);
    send_item(OP_STORE, -8'sd128, 8'sd127, 1'b1);
    send_item(OP_STORE, 8'sd0, -8'sd1, 1'b0);
    send_item(OP_LATCH, -8'sd1, -8'sd1, 1'b1);
  endtask

  // Fills past the window so the oldest entries are overwritten.
  task automatic test_full_window();
    send_item(OP_STORE, -8'sd40, 8'sd3, 1'b1);
    send_item(OP_STORE, -8'sd41, 8'sd3, 1'b0);
    send_item(OP_STORE, -8'sd90, -8'sd100, 1'b1);
    send_item(OP_LATCH, 8'sd0, 8'sd0, 1'b1);
    send_item(OP_STORE, 8'sd10, 8'sd64, 1'b0);
    send_item(OP_STORE, -8'sd2, -8'sd65, 1'b1);
    send_item(OP_LATCH, 8'sd0, 8'sd0, 1'b1);
  endtask

  // Clear empties the history; new samples start again from the first slot.
  task automatic test_clear();
    send_item(OP_CLEAR, 8'sd127, 8'sd127, 1'b1);
    send_item(OP_LATCH, 8'sd0, 8'sd0, 1'b1);
    send_item(OP_STORE, -8'sd77, 8'sd33, 1'b0);
    send_item(OP_LATCH, 8'sd0, 8'sd0, 1'b1);
  endtask

  // Runs of stores closed by a latch, with some clears and ignored items mixed in.
  task automatic test_random_sequences(input int target);
    int accepted;
    int run_len;
    int pick;
    accepted = 0;
    while (accepted < target) begin
      run_len = $urandom_range(0, 9);
      for (int i = 0; i < run_len; i++) begin
        send_item(OP_STORE, pick_sample(), pick_sample(), 1'($urandom));
        accepted++;
      end
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        send_item(OP_LATCH, 8'($urandom), 8'($urandom), 1'b1);
        accepted++;
      end else if (pick < 17) begin
        send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
        accepted++;
      end else if (pick < 18) begin
        send_item(OP_LATCH, 8'($urandom), 8'($urandom), 1'b0);
      end else if (pick < 19) begin
        send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
        send_item(OP_LATCH, 8'($urandom), 8'($urandom), 1'b1);
        accepted += 2;
      end
    end
  endtask

  // Same sequences with no gaps and no stalls on either side.
  task automatic test_back_to_back(input int target);
    quiet = 1'b1;
    test_random_sequences(target);
    quiet = 1'b0;
  endtask

  // Result side: random stalls per result, and the check against the oldest prediction.
  initial begin
    int       stall;
    medians_t exp_m;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_medians.size() == 0) begin
          $error("unexpected result: central_median=%0d peripheral_median=%0d sample_count=%0d",
                 out_ch.central_median, out_ch.peripheral_median, out_ch.sample_count);
          mismatches++;
        end else begin
          exp_m = pending_medians.pop_front();
          if (out_ch.central_median !== exp_m.central) begin
            $error("central_median: expected %0d, actual %0d",
                   exp_m.central, out_ch.central_median);
            mismatches++;
          end
          if (out_ch.peripheral_median !== exp_m.peripheral) begin
            $error("peripheral_median: expected %0d, actual %0d",
                   exp_m.peripheral, out_ch.peripheral_median);
            mismatches++;
          end
          if (out_ch.sample_count !== exp_m.count) begin
            $error("sample_count: expected %0d, actual %0d",
                   exp_m.count, out_ch.sample_count);
            mismatches++;
          end
        end
        stall = quiet ? 0 : $urandom_range(0, 3);
        out_ch.ready <= (stall == 0);
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= (stall == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Reset, the test sequence and the final verdict.
  initial begin
    mismatches = 0;
    quiet = 1'b0;
    hist_fill = 0;
    hist_slot = 0;
    for (int i = 0; i < DEPTH; i++) begin
      central_hist[i] = '0;
      peripheral_hist[i] = '0;
    end
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_STORE;
    in_ch.central_sample <= '0;
    in_ch.peripheral_sample <= '0;
    in_ch.transfer_ok <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_ignored();
    test_extremes();
    test_full_window();
    test_clear();
    test_random_sequences(650);
    test_back_to_back(150);
    test_random_sequences(150);
    in_ch.valid <= 1'b0;

    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
